// ===== sv/gnb_pkg.sv =====
// Shared types and constants of the Gaussian naive Bayes classifier.
`default_nettype none

package gnb_pkg;

   localparam int NUM_FEATURES = 4;
   localparam int VAR_W        = 48;
   localparam int D_MOD_BITS   = 18;
   localparam int DIV_STEPS    = 64;
   localparam int SQ_STEPS     = 16;

   localparam logic OP_TRAIN   = 1'b0;
   localparam logic OP_PREDICT = 1'b1;

   localparam logic [31:0] LN2_Q16         = 32'd45426;
   localparam logic [63:0] LN_SQRT_2PI_Q16 = 64'd60223;
   localparam logic [63:0] LOG_BIAS        = 64'd47632613376;
   localparam logic [63:0] INV_NUMERATOR   = 64'd549755813888;
   localparam logic [30:0] VAR_FLOOR_RESET = 31'd66;
   localparam logic [5:0]  NORM_POINT      = 6'd31;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_START,
      ST_T_RD,
      ST_T_WR,
      ST_F_CLASS,
      ST_F_RD,
      ST_F_MEAN,
      ST_F_MEAN_WAIT,
      ST_F_E2_WAIT,
      ST_F_M2,
      ST_F_VAR,
      ST_F_INV_WAIT,
      ST_F_NORM,
      ST_F_SQ,
      ST_F_SQ_ADJ,
      ST_F_LOGMUL,
      ST_F_WRITE,
      ST_F_DONE,
      ST_P_CLASS,
      ST_P_RD,
      ST_P_LOAD,
      ST_P_SQ,
      ST_P_HI,
      ST_P_LO,
      ST_P_ACC,
      ST_P_CMP,
      ST_P_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== sv/gnb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gnb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/gnb_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, unsigned 64 by 64 bits.
`default_nettype none

module gnb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [63:0]                  dividend,
   input  logic [63:0]                  divisor,
   output logic [63:0]                  quotient,
   output gnb_pkg::div_status_type      status
);
   import gnb_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [64:0] rem_sh;
   logic [64:0] rem_diff;
   logic        ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[63]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      ge       = (rem_sh >= {1'b0, dvs_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_diff[63:0] : rem_sh[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== sv/gaussian_naive_bayes_classifier.sv =====
// Top level of the Gaussian naive Bayes classifier: sequencer, shared multiplier and stores.
//
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  opcode, four Q16.16 features, label, last flag
// rsp       out        rsp_valid/rsp_ready  predicted_class, best_score
// csr       in         csr_valid/csr_ready  var_floor (Q16.16, 31 bits)
//
// A training transaction reads and writes the accumulator for each of the four features;
// one marked last then fits the model for each populated class and feature, set by three
// 64-step divisions, the normalisation steps and 16 squaring steps. A prediction visits
// every fitted class and skips each empty one, with three multiplies per feature through
// the single 32 x 32 multiplier. Reset is synchronous and needs no clearing pass:
// accumulator entries carry valid bits. req_ready is high only while the sequencer is
// idle; a finished result waits in the output register and a new transaction is taken
// meanwhile, only the next prediction's delivery waits for rsp_ready.
`default_nettype none

module gaussian_naive_bayes_classifier #(
   parameter int NUM_CLASSES = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_feat_s,
   input  logic signed [31:0] req_feat_sdot,
   input  logic signed [31:0] req_feat_d,
   input  logic signed [31:0] req_feat_ddot,
   input  logic [1:0]         req_class_label,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_predicted_class,
   output logic signed [63:0] rsp_best_score,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_var_floor
);
   import gnb_pkg::*;

   localparam int CW    = $clog2(NUM_CLASSES);
   localparam int AW    = CW + 2;
   localparam int SLOTS = NUM_CLASSES * NUM_FEATURES;

   // Truncating remainder by 4.0 (2^18 in Q16.16), keeping the sign of the dividend.
   function automatic logic [31:0] mod_d(input logic [31:0] x);
      logic [31:0] m;
      logic [31:0] r;
      m = x[31] ? (32'd0 - x) : x;
      r = {14'd0, m[D_MOD_BITS-1:0]};
      return x[31] ? (32'd0 - r) : r;
   endfunction

   state_type state_ff, state_in;

   logic [CW-1:0]  cls_ff, cls_in;
   logic [1:0]     f_ff, f_in;
   logic [31:0]    x_ff [NUM_FEATURES];
   logic [31:0]    x_in [NUM_FEATURES];
   logic           label_ok_ff, label_ok_in;
   logic           last_ff, last_in;
   logic           clear_pending_ff, clear_pending_in;
   logic           model_fitted_ff, model_fitted_in;
   logic           class_ok_ff [NUM_CLASSES];
   logic           class_ok_in [NUM_CLASSES];
   logic [31:0]    count_ff [NUM_CLASSES];
   logic [31:0]    count_in [NUM_CLASSES];
   logic           acc_valid_ff [SLOTS];
   logic           acc_valid_in [SLOTS];
   logic [31:0]    n_ff, n_in;
   logic           sneg_ff, sneg_in;
   logic [31:0]    mean_ff, mean_in;
   logic [63:0]    wa_ff, wa_in;
   logic [63:0]    wb_ff, wb_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic [31:0]    inv_ff, inv_in;
   logic [31:0]    ls_ff, ls_in;
   logic [VAR_W-1:0] y_ff, y_in;
   logic [5:0]     p_ff, p_in;
   logic [15:0]    frac_ff, frac_in;
   logic [3:0]     sq_cnt_ff, sq_cnt_in;
   logic [31:0]    d_ff, d_in;
   logic [63:0]    total_ff, total_in;
   logic [63:0]    best_ff, best_in;
   logic [CW-1:0]  best_cls_ff, best_cls_in;
   logic           best_set_ff, best_set_in;
   logic [63:0]    prod_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_class_ff, rsp_class_in;
   logic [63:0]    rsp_score_ff, rsp_score_in;
   logic [30:0]    floor_ff;

   // Shared multiplier operands.
   logic [31:0] mul_a, mul_b;

   // Divider hookup.
   logic            div_start;
   logic [63:0]     div_dividend, div_divisor, div_q;
   div_status_type  div_stat;

   // Stores.
   logic [AW-1:0]   slot;
   logic            acc_rd_en, acc_wr_en, fit_rd_en, fit_wr_en;
   logic [127:0]    acc_rd, acc_wr;
   logic [95:0]     fit_rd, fit_wr;

   // Datapath helpers.
   logic           req_hs, cls_last, cnt_zero, norm_done, out_free;
   logic [31:0]    x_cur, x_mag, mean_mag, cnt_base;
   logic [63:0]    sum_rd, sq_rd, b_ext, sum_add, sum_new, sq_new, sum_mag;
   logic [64:0]    sq_add;
   logic           sum_ovf;
   logic [31:0]    mean_sat;
   logic [63:0]    var_diff;
   logic [VAR_W-1:0] var_raw, var_fl, var_val;
   logic [30:0]    floor_eff;
   logic [63:0]    ls_full;
   logic [32:0]    sq_t;
   logic [32:0]    diff33, dmag33;
   logic [63:0]    quad, term, score;
   logic           better;

   assign req_hs    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign slot      = {cls_ff, f_ff};
   assign cls_last  = (cls_ff == CW'(NUM_CLASSES - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      x_cur    = x_ff[f_ff];
      x_mag    = x_cur[31] ? (32'd0 - x_cur) : x_cur;
      cnt_zero = (count_ff[cls_ff] == 32'd0);
      norm_done = (y_ff[VAR_W-1:32] == '0) && y_ff[31];

      // Training: saturating sum and sum of squares; an unwritten entry reads as zero.
      sum_rd  = acc_valid_ff[slot] ? acc_rd[63:0]   : 64'd0;
      sq_rd   = acc_valid_ff[slot] ? acc_rd[127:64] : 64'd0;
      b_ext   = {{32{x_cur[31]}}, x_cur};
      sum_add = sum_rd + b_ext;
      sum_ovf = (sum_rd[63] == b_ext[63]) && (sum_add[63] != sum_rd[63]);
      sum_new = sum_ovf ? (b_ext[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                        : sum_add;
      sq_add  = {1'b0, sq_rd} + {1'b0, prod_ff};
      sq_new  = sq_add[64] ? '1 : sq_add[63:0];

      // Fitting.
      sum_mag  = sum_rd[63] ? (64'd0 - sum_rd) : sum_rd;
      if (sneg_ff) begin
         mean_sat = (div_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
      end else begin
         mean_sat = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
      end
      mean_mag  = mean_ff[31] ? (32'd0 - mean_ff) : mean_ff;
      var_diff  = (wa_ff > prod_ff) ? (wa_ff - prod_ff) : 64'd0;
      var_raw   = var_diff[63:16];
      floor_eff = (floor_ff == 31'd0) ? 31'd1 : floor_ff;
      var_fl    = VAR_W'(floor_eff);
      var_val   = (var_raw < var_fl) ? var_fl : var_raw;
      ls_full   = prod_ff - LOG_BIAS;
      sq_t      = prod_ff[63:31];

      // Prediction.
      diff33 = {x_cur[31], x_cur} - {fit_rd[31], fit_rd[31:0]};
      dmag33 = diff33[32] ? (33'd0 - diff33) : diff33;
      quad   = (wa_ff + {32'd0, prod_ff[63:32]}) >> 8;
      term   = quad + {{32{ls_ff[31]}}, ls_ff} + LN_SQRT_2PI_Q16;
      score  = 64'd0 - total_ff;
      better = !best_set_ff || ($signed(score) > $signed(best_ff));

      cnt_base = clear_pending_ff ? 32'd0 : count_ff[cls_ff];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               if (req_opcode == OP_PREDICT) begin
                  state_in = model_fitted_ff ? ST_P_CLASS : ST_P_OUT;
               end else begin
                  state_in = ST_T_START;
               end
            end
         end
         ST_T_START: begin
            if (label_ok_ff) begin
               state_in = ST_T_RD;
            end else begin
               state_in = last_ff ? ST_F_CLASS : ST_IDLE;
            end
         end
         ST_T_RD:  state_in = ST_T_WR;
         ST_T_WR: begin
            if (f_ff == 2'd3) begin
               state_in = last_ff ? ST_F_CLASS : ST_IDLE;
            end else begin
               state_in = ST_T_RD;
            end
         end
         ST_F_CLASS: begin
            if (cnt_zero) begin
               state_in = cls_last ? ST_F_DONE : ST_F_CLASS;
            end else begin
               state_in = ST_F_RD;
            end
         end
         ST_F_RD:        state_in = ST_F_MEAN;
         ST_F_MEAN:      state_in = ST_F_MEAN_WAIT;
         ST_F_MEAN_WAIT: state_in = div_stat.done ? ST_F_E2_WAIT : ST_F_MEAN_WAIT;
         ST_F_E2_WAIT:   state_in = div_stat.done ? ST_F_M2 : ST_F_E2_WAIT;
         ST_F_M2:        state_in = ST_F_VAR;
         ST_F_VAR:       state_in = ST_F_INV_WAIT;
         ST_F_INV_WAIT:  state_in = div_stat.done ? ST_F_NORM : ST_F_INV_WAIT;
         ST_F_NORM:      state_in = norm_done ? ST_F_SQ : ST_F_NORM;
         ST_F_SQ:        state_in = ST_F_SQ_ADJ;
         ST_F_SQ_ADJ: begin
            state_in = (sq_cnt_ff == 4'(SQ_STEPS - 1)) ? ST_F_LOGMUL : ST_F_SQ;
         end
         ST_F_LOGMUL:    state_in = ST_F_WRITE;
         ST_F_WRITE: begin
            if (f_ff == 2'd3) begin
               state_in = cls_last ? ST_F_DONE : ST_F_CLASS;
            end else begin
               state_in = ST_F_RD;
            end
         end
         ST_F_DONE:      state_in = ST_IDLE;
         ST_P_CLASS: begin
            if (!class_ok_ff[cls_ff]) begin
               state_in = cls_last ? ST_P_OUT : ST_P_CLASS;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_P_RD:   state_in = ST_P_LOAD;
         ST_P_LOAD: state_in = ST_P_SQ;
         ST_P_SQ:   state_in = ST_P_HI;
         ST_P_HI:   state_in = ST_P_LO;
         ST_P_LO:   state_in = ST_P_ACC;
         ST_P_ACC:  state_in = (f_ff == 2'd3) ? ST_P_CMP : ST_P_RD;
         ST_P_CMP:  state_in = cls_last ? ST_P_OUT : ST_P_CLASS;
         ST_P_OUT:  state_in = out_free ? ST_IDLE : ST_P_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs.
   always_comb begin
      cls_in           = cls_ff;
      f_in             = f_ff;
      x_in             = x_ff;
      label_ok_in      = label_ok_ff;
      last_in          = last_ff;
      clear_pending_in = clear_pending_ff;
      model_fitted_in  = model_fitted_ff;
      class_ok_in      = class_ok_ff;
      count_in         = count_ff;
      acc_valid_in     = acc_valid_ff;
      n_in             = n_ff;
      sneg_in          = sneg_ff;
      mean_in          = mean_ff;
      wa_in            = wa_ff;
      wb_in            = wb_ff;
      var_in           = var_ff;
      inv_in           = inv_ff;
      ls_in            = ls_ff;
      y_in             = y_ff;
      p_in             = p_ff;
      frac_in          = frac_ff;
      sq_cnt_in        = sq_cnt_ff;
      d_in             = d_ff;
      total_in         = total_ff;
      best_in          = best_ff;
      best_cls_in      = best_cls_ff;
      best_set_in      = best_set_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_class_in     = rsp_class_ff;
      rsp_score_in     = rsp_score_ff;
      mul_a            = 32'd0;
      mul_b            = 32'd0;
      div_start        = 1'b0;
      div_dividend     = 64'd0;
      div_divisor      = 64'd1;
      acc_rd_en        = 1'b0;
      acc_wr_en        = 1'b0;
      acc_wr           = {sq_new, sum_new};
      fit_rd_en        = 1'b0;
      fit_wr_en        = 1'b0;
      fit_wr           = {ls_full[48:17], inv_ff, mean_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_hs) begin
               x_in[0]     = req_feat_s;
               x_in[1]     = req_feat_sdot;
               x_in[2]     = mod_d(req_feat_d);
               x_in[3]     = req_feat_ddot;
               label_ok_in = ({4'd0, req_class_label} < 6'(NUM_CLASSES));
               last_in     = req_last_sample;
               cls_in      = (req_opcode == OP_PREDICT) ? CW'(0) : CW'(req_class_label);
               best_in     = 64'h8000_0000_0000_0000;
               best_cls_in = '0;
               best_set_in = 1'b0;
            end
         end
         ST_T_START: begin
            f_in = 2'd0;
            if (clear_pending_ff) begin
               for (int i = 0; i < NUM_CLASSES; i++) begin
                  count_in[i] = 32'd0;
               end
               for (int i = 0; i < SLOTS; i++) begin
                  acc_valid_in[i] = 1'b0;
               end
               clear_pending_in = 1'b0;
            end
            if (label_ok_ff) begin
               count_in[cls_ff] = (cnt_base == '1) ? cnt_base : (cnt_base + 32'd1);
            end else if (last_ff) begin
               cls_in = '0;
            end
         end
         ST_T_RD: begin
            acc_rd_en = 1'b1;
            mul_a     = x_mag;
            mul_b     = x_mag;
         end
         ST_T_WR: begin
            acc_wr_en          = 1'b1;
            acc_valid_in[slot] = 1'b1;
            if (f_ff == 2'd3) begin
               cls_in = '0;
            end else begin
               f_in = f_ff + 2'd1;
            end
         end
         ST_F_CLASS: begin
            f_in                = 2'd0;
            n_in                = count_ff[cls_ff];
            class_ok_in[cls_ff] = !cnt_zero;
            if (cnt_zero && !cls_last) begin
               cls_in = cls_ff + CW'(1);
            end
         end
         ST_F_RD: begin
            acc_rd_en = 1'b1;
         end
         ST_F_MEAN: begin
            sneg_in      = sum_rd[63];
            wb_in        = sq_rd;
            div_start    = 1'b1;
            div_dividend = sum_mag;
            div_divisor  = {32'd0, n_ff};
         end
         ST_F_MEAN_WAIT: begin
            if (div_stat.done) begin
               mean_in      = mean_sat;
               div_start    = 1'b1;
               div_dividend = wb_ff;
               div_divisor  = {32'd0, n_ff};
            end
         end
         ST_F_E2_WAIT: begin
            if (div_stat.done) begin
               wa_in = div_q;
            end
         end
         ST_F_M2: begin
            mul_a = mean_mag;
            mul_b = mean_mag;
         end
         ST_F_VAR: begin
            var_in       = var_val;
            div_start    = 1'b1;
            div_dividend = INV_NUMERATOR;
            div_divisor  = 64'(var_val);
         end
         ST_F_INV_WAIT: begin
            if (div_stat.done) begin
               inv_in = (div_q[63:32] != 32'd0) ? '1 : div_q[31:0];
               y_in   = var_ff;
               p_in   = NORM_POINT;
            end
         end
         ST_F_NORM: begin
            // Bring the leading one to bit 31, tracking the integer part of log2.
            if (y_ff[VAR_W-1:32] != '0) begin
               y_in = y_ff >> 1;
               p_in = p_ff + 6'd1;
            end else if (!y_ff[31]) begin
               y_in = y_ff << 1;
               p_in = p_ff - 6'd1;
            end else begin
               sq_cnt_in = '0;
               frac_in   = '0;
            end
         end
         ST_F_SQ: begin
            mul_a = y_ff[31:0];
            mul_b = y_ff[31:0];
         end
         ST_F_SQ_ADJ: begin
            frac_in   = {frac_ff[14:0], sq_t[32]};
            y_in      = VAR_W'(sq_t[32] ? sq_t[32:1] : sq_t[31:0]);
            sq_cnt_in = sq_cnt_ff + 4'd1;
         end
         ST_F_LOGMUL: begin
            mul_a = {10'd0, p_ff, frac_ff};
            mul_b = LN2_Q16;
         end
         ST_F_WRITE: begin
            fit_wr_en = 1'b1;
            if (f_ff == 2'd3) begin
               if (!cls_last) begin
                  cls_in = cls_ff + CW'(1);
               end
            end else begin
               f_in = f_ff + 2'd1;
            end
         end
         ST_F_DONE: begin
            model_fitted_in  = 1'b1;
            clear_pending_in = 1'b1;
         end
         ST_P_CLASS: begin
            f_in     = 2'd0;
            total_in = 64'd0;
            if (!class_ok_ff[cls_ff] && !cls_last) begin
               cls_in = cls_ff + CW'(1);
            end
         end
         ST_P_RD: begin
            fit_rd_en = 1'b1;
         end
         ST_P_LOAD: begin
            d_in   = dmag33[31:0];
            inv_in = fit_rd[63:32];
            ls_in  = fit_rd[95:64];
         end
         ST_P_SQ: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         ST_P_HI: begin
            wb_in = {32'd0, prod_ff[31:0]};
            mul_a = prod_ff[63:32];
            mul_b = inv_ff;
         end
         ST_P_LO: begin
            wa_in = prod_ff;
            mul_a = wb_ff[31:0];
            mul_b = inv_ff;
         end
         ST_P_ACC: begin
            total_in = total_ff + term;
            if (f_ff != 2'd3) begin
               f_in = f_ff + 2'd1;
            end
         end
         ST_P_CMP: begin
            if (better) begin
               best_in     = score;
               best_cls_in = cls_ff;
               best_set_in = 1'b1;
            end
            if (!cls_last) begin
               cls_in = cls_ff + CW'(1);
            end
         end
         ST_P_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_class_in = 2'(best_cls_ff);
               rsp_score_in = best_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         clear_pending_ff <= 1'b0;
         model_fitted_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         floor_ff         <= VAR_FLOOR_RESET;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            class_ok_ff[i] <= 1'b0;
            count_ff[i]    <= 32'd0;
         end
         for (int i = 0; i < SLOTS; i++) begin
            acc_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff         <= state_in;
         clear_pending_ff <= clear_pending_in;
         model_fitted_ff  <= model_fitted_in;
         rsp_valid_ff     <= rsp_valid_in;
         class_ok_ff      <= class_ok_in;
         count_ff         <= count_in;
         acc_valid_ff     <= acc_valid_in;
         if (csr_valid && csr_ready) begin
            floor_ff <= csr_var_floor;
         end
      end
      cls_ff      <= cls_in;
      f_ff        <= f_in;
      x_ff        <= x_in;
      label_ok_ff <= label_ok_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      sneg_ff     <= sneg_in;
      mean_ff     <= mean_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      var_ff      <= var_in;
      inv_ff      <= inv_in;
      ls_ff       <= ls_in;
      y_ff        <= y_in;
      p_ff        <= p_in;
      frac_ff     <= frac_in;
      sq_cnt_ff   <= sq_cnt_in;
      d_ff        <= d_in;
      total_ff    <= total_in;
      best_ff     <= best_in;
      best_cls_ff <= best_cls_in;
      best_set_ff <= best_set_in;
      prod_ff     <= {32'd0, mul_a} * {32'd0, mul_b};
      rsp_class_ff <= rsp_class_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_class = rsp_class_ff;
   assign rsp_best_score      = rsp_score_ff;

   // Accumulators: {sum of squares, sum} per class and feature.
   gnb_ram #(
      .WIDTH (128),
      .DEPTH (SLOTS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (slot),
      .wr_data (acc_wr),
      .rd_en   (acc_rd_en),
      .rd_addr (slot),
      .rd_data (acc_rd)
   );

   // Fitted model: {log sigma, 1/(2 var), mean} per class and feature.
   gnb_ram #(
      .WIDTH (96),
      .DEPTH (SLOTS)
   ) u_fit_ram (
      .clock   (clock),
      .wr_en   (fit_wr_en),
      .wr_addr (slot),
      .wr_data (fit_wr),
      .rd_en   (fit_rd_en),
      .rd_addr (slot),
      .rd_data (fit_rd)
   );

   gnb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .status   (div_stat)
   );

   // The divider only finishes while the sequencer is waiting for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_F_MEAN_WAIT || state_ff == ST_F_E2_WAIT ||
                         state_ff == ST_F_INV_WAIT))
      else $error("divider finished outside a wait state");

   // A new division is never launched over one in flight.
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // Completing a fit marks the model usable and arms the accumulator clear.
   a_fit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F_DONE) |=> (model_fitted_ff && clear_pending_ff))
      else $error("fit completion did not update model flags");

   // A chosen class always had samples at the last fit.
   a_best_fitted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_OUT && best_set_ff) |-> class_ok_ff[best_cls_ff])
      else $error("prediction picked an empty class");

endmodule

`default_nettype wire
